FILE: hdl/frpc_pkg.sv
// Shared constants, widths, register codes and trig table functions for the
// fixed-point rotate / project / cull pipeline. No dependencies.

package frpc_pkg;

	localparam int TRIG_BITS  = 8;
	localparam int SCALE_BITS = 8;

	localparam int COORD_W  = 16;
	localparam int ANG_W    = 9;
	localparam int SCALE_W  = 14;
	localparam int CENTER_W = 8;
	localparam int CFG_W    = 14;
	localparam int IDX_W    = 3;
	localparam int SCR_W    = 8;

	localparam int TRIG_W = TRIG_BITS + 2;
	localparam int PT_W   = COORD_W + TRIG_W;
	localparam int RX_W   = PT_W + 1;
	localparam int PZ_W   = RX_W + TRIG_W;
	localparam int RY_W   = PZ_W + 1;
	localparam int PX_W   = RX_W + SCALE_W + 1;
	localparam int PY_W   = RY_W + SCALE_W + 1;
	localparam int SHX    = TRIG_BITS - 1 + SCALE_BITS;
	localparam int SHY    = 2 * TRIG_BITS - 1 + SCALE_BITS;
	localparam int Q_W    = SCR_W + 1;

	localparam int NSTG = 8;

	localparam logic [ANG_W-1:0]    DEG_90     = ANG_W'(90);
	localparam logic [ANG_W-1:0]    DEG_180    = ANG_W'(180);
	localparam logic [ANG_W-1:0]    DEG_270    = ANG_W'(270);
	localparam logic [ANG_W-1:0]    DEG_360    = ANG_W'(360);
	localparam logic [ANG_W-1:0]    DEG_450    = ANG_W'(450);
	localparam logic [SCALE_W-1:0]  SCALE_RST  = SCALE_W'(64);
	localparam logic [CENTER_W-1:0] CENTER_RST = CENTER_W'(64);

	// table entries are round(256*sin), rescaled to TRIG_BITS fraction bits
	localparam int QS_R    = (TRIG_BITS < 8) ? 8 - TRIG_BITS : 0;
	localparam int QS_L    = (TRIG_BITS > 8) ? TRIG_BITS - 8 : 0;
	localparam int QS_HALF = (1 << QS_R) >> 1;

	typedef enum logic [IDX_W-1:0] {
		REG_ROLL   = 3'd0,
		REG_PITCH  = 3'd1,
		REG_SCALE  = 3'd2,
		REG_CENTER = 3'd3
	} cfg_reg_t;

	localparam logic [8:0] QSIN [0:90] = '{
		9'd0,   9'd4,   9'd9,   9'd13,  9'd18,  9'd22,  9'd27,  9'd31,  9'd36,  9'd40,
		9'd44,  9'd49,  9'd53,  9'd58,  9'd62,  9'd66,  9'd71,  9'd75,  9'd79,  9'd83,
		9'd88,  9'd92,  9'd96,  9'd100, 9'd104, 9'd108, 9'd112, 9'd116, 9'd120, 9'd124,
		9'd128, 9'd132, 9'd136, 9'd139, 9'd143, 9'd147, 9'd150, 9'd154, 9'd158, 9'd161,
		9'd165, 9'd168, 9'd171, 9'd175, 9'd178, 9'd181, 9'd184, 9'd187, 9'd190, 9'd193,
		9'd196, 9'd199, 9'd202, 9'd204, 9'd207, 9'd210, 9'd212, 9'd215, 9'd217, 9'd219,
		9'd222, 9'd224, 9'd226, 9'd228, 9'd230, 9'd232, 9'd234, 9'd236, 9'd237, 9'd239,
		9'd241, 9'd242, 9'd243, 9'd245, 9'd246, 9'd247, 9'd248, 9'd249, 9'd250, 9'd251,
		9'd252, 9'd253, 9'd254, 9'd254, 9'd255, 9'd255, 9'd255, 9'd256, 9'd256, 9'd256,
		9'd256
	};

	function automatic logic signed [TRIG_W-1:0] quarter_val(logic [ANG_W-1:0] d);
		logic [TRIG_W-1:0] v;
		v = TRIG_W'(((32'(QSIN[d[6:0]]) + QS_HALF) >> QS_R) << QS_L);
		return $signed(v);
	endfunction

	function automatic logic [ANG_W-1:0] mod360(logic [ANG_W-1:0] a);
		return (a >= DEG_360) ? a - DEG_360 : a;
	endfunction

	// d in 0..359
	function automatic logic signed [TRIG_W-1:0] sin_deg(logic [ANG_W-1:0] d);
		logic signed [TRIG_W-1:0] r;
		if (d <= DEG_90) begin
			r = quarter_val(d);
		end else if (d <= DEG_180) begin
			r = quarter_val(DEG_180 - d);
		end else if (d <= DEG_270) begin
			r = -quarter_val(d - DEG_180);
		end else begin
			r = -quarter_val(DEG_360 - d);
		end
		return r;
	endfunction

	function automatic logic signed [TRIG_W-1:0] cos_deg(logic [ANG_W-1:0] d);
		return sin_deg((d <= DEG_90) ? DEG_90 - d : DEG_450 - d);
	endfunction

endpackage

FILE: hdl/fixed_point_rotate_project_cull_unit.sv
// Throughput: one point per cycle while out_stall is low.
// Eight register stages, each holding about one multiply or a short add chain; a stage
// advances whenever it is empty or the stage after it moves, so bubbles collapse.
// Reset (arst_n low, async): all stage valids clear, roll/pitch 0, scale 64, center 64.
// Trig values are looked up and registered on the config write itself.
// Depends on frpc_pkg.

module fixed_point_rotate_project_cull_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [frpc_pkg::IDX_W-1:0]            cfg_idx,
	input  logic [frpc_pkg::CFG_W-1:0]            cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [frpc_pkg::COORD_W-1:0]   point_x,
	input  logic signed [frpc_pkg::COORD_W-1:0]   point_y,
	input  logic signed [frpc_pkg::COORD_W-1:0]   point_z,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [frpc_pkg::SCR_W-1:0]            screen_x,
	output logic [frpc_pkg::SCR_W-1:0]            screen_y,
	output logic                                  facing
);

	localparam int TRIG_W  = frpc_pkg::TRIG_W;
	localparam int COORD_W = frpc_pkg::COORD_W;
	localparam int PT_W    = frpc_pkg::PT_W;
	localparam int RX_W    = frpc_pkg::RX_W;
	localparam int PZ_W    = frpc_pkg::PZ_W;
	localparam int RY_W    = frpc_pkg::RY_W;
	localparam int PX_W    = frpc_pkg::PX_W;
	localparam int PY_W    = frpc_pkg::PY_W;
	localparam int SHX     = frpc_pkg::SHX;
	localparam int SHY     = frpc_pkg::SHY;
	localparam int Q_W     = frpc_pkg::Q_W;
	localparam int SCR_W   = frpc_pkg::SCR_W;
	localparam int NSTG    = frpc_pkg::NSTG;

	// config / trig registers
	logic signed [TRIG_W-1:0]            cr_q, sr_q, cp_q, sp_q;
	logic [frpc_pkg::SCALE_W-1:0]        scale_q;
	logic [frpc_pkg::CENTER_W-1:0]       center_q;
	logic [frpc_pkg::ANG_W-1:0]          ang_wr;
	logic signed [frpc_pkg::SCALE_W:0]   scl_sg;

	assign ang_wr = frpc_pkg::mod360(cfg_wdata[frpc_pkg::ANG_W-1:0]);
	assign scl_sg = $signed({1'b0, scale_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_q     <= frpc_pkg::cos_deg('0);
			sr_q     <= frpc_pkg::sin_deg('0);
			cp_q     <= frpc_pkg::cos_deg('0);
			sp_q     <= frpc_pkg::sin_deg('0);
			scale_q  <= frpc_pkg::SCALE_RST;
			center_q <= frpc_pkg::CENTER_RST;
		end else if (cfg_we) begin
			unique case (frpc_pkg::cfg_reg_t'(cfg_idx))
				frpc_pkg::REG_ROLL: begin
					cr_q <= frpc_pkg::cos_deg(ang_wr);
					sr_q <= frpc_pkg::sin_deg(ang_wr);
				end
				frpc_pkg::REG_PITCH: begin
					cp_q <= frpc_pkg::cos_deg(ang_wr);
					sp_q <= frpc_pkg::sin_deg(ang_wr);
				end
				frpc_pkg::REG_SCALE: begin
					scale_q <= cfg_wdata[frpc_pkg::SCALE_W-1:0];
				end
				frpc_pkg::REG_CENTER: begin
					center_q <= cfg_wdata[frpc_pkg::CENTER_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// stage valids and load enables
	logic [NSTG:1] vld_q;
	logic [NSTG:1] ld;

	always_comb begin
		ld[NSTG] = !vld_q[NSTG] || !out_stall;
		for (int k = NSTG - 1; k >= 1; k--) begin
			ld[k] = !vld_q[k] || ld[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (ld[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_stall  = !ld[1];
	assign out_valid = vld_q[NSTG];

	// datapath registers
	logic signed [COORD_W-1:0] x_s1, y_s1, z_s1;
	logic signed [PT_W-1:0]    xc_s2, ys_s2, xs_s2, yc_s2;
	logic signed [COORD_W-1:0] z_s2, z_s3;
	logic signed [RX_W-1:0]    rx_s3, t_s3;
	logic signed [PX_W-1:0]    prodx_s4;
	logic signed [PZ_W-1:0]    tcp_s4, tsp_s4;
	logic signed [PT_W-1:0]    zsp_s4, zcp_s4;
	logic [Q_W-1:0]            qx_s5;
	logic                      negx_s5;
	logic signed [RY_W-1:0]    ry_s5;
	logic                      fac_s5, fac_s6, fac_s7;
	logic [SCR_W-1:0]          px_s6, px_s7;
	logic signed [PY_W-1:0]    prody_s6;
	logic [Q_W-1:0]            qy_s7;
	logic                      negy_s7;
	logic [SCR_W-1:0]          screen_x_s8, screen_y_s8;
	logic                      facing_s8;

	// comb helpers
	logic signed [RY_W-1:0] ry_c, rz_c;
	logic [SHX+Q_W-1:0]     lowx_c, magx_c;
	logic [SHY+Q_W-1:0]     lowy_c, magy_c;
	logic [SCR_W-1:0]       rndx_c, rndy_c, py_c;

	always_comb begin
		ry_c   = RY_W'(tcp_s4) + (RY_W'(zsp_s4) <<< frpc_pkg::TRIG_BITS);
		rz_c   = (RY_W'(zcp_s4) <<< frpc_pkg::TRIG_BITS) - RY_W'(tsp_s4);
		// only the low bits of the magnitude reach the wrapped result
		lowx_c = prodx_s4[SHX+Q_W-1:0];
		magx_c = prodx_s4[PX_W-1] ? (~lowx_c + (SHX+Q_W)'(1)) : lowx_c;
		rndx_c = qx_s5[Q_W-1:1] + SCR_W'(qx_s5[0]);
		lowy_c = prody_s6[SHY+Q_W-1:0];
		magy_c = prody_s6[PY_W-1] ? (~lowy_c + (SHY+Q_W)'(1)) : lowy_c;
		rndy_c = qy_s7[Q_W-1:1] + SCR_W'(qy_s7[0]);
		py_c   = negy_s7 ? -rndy_c : rndy_c;
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			x_s1 <= point_x;
			y_s1 <= point_y;
			z_s1 <= point_z;
		end
		if (ld[2]) begin
			xc_s2 <= PT_W'(x_s1) * PT_W'(cr_q);
			ys_s2 <= PT_W'(y_s1) * PT_W'(sr_q);
			xs_s2 <= PT_W'(x_s1) * PT_W'(sr_q);
			yc_s2 <= PT_W'(y_s1) * PT_W'(cr_q);
			z_s2  <= z_s1;
		end
		if (ld[3]) begin
			rx_s3 <= RX_W'(xc_s2) + RX_W'(ys_s2);
			t_s3  <= RX_W'(yc_s2) - RX_W'(xs_s2);
			z_s3  <= z_s2;
		end
		if (ld[4]) begin
			prodx_s4 <= PX_W'(rx_s3) * PX_W'(scl_sg);
			tcp_s4   <= PZ_W'(t_s3) * PZ_W'(cp_q);
			tsp_s4   <= PZ_W'(t_s3) * PZ_W'(sp_q);
			zsp_s4   <= PT_W'(z_s3) * PT_W'(sp_q);
			zcp_s4   <= PT_W'(z_s3) * PT_W'(cp_q);
		end
		if (ld[5]) begin
			qx_s5   <= magx_c[SHX+Q_W-1:SHX];
			negx_s5 <= prodx_s4[PX_W-1];
			ry_s5   <= ry_c;
			fac_s5  <= !rz_c[RY_W-1] && (rz_c != '0);
		end
		if (ld[6]) begin
			px_s6    <= negx_s5 ? -rndx_c : rndx_c;
			prody_s6 <= PY_W'(ry_s5) * PY_W'(scl_sg);
			fac_s6   <= fac_s5;
		end
		if (ld[7]) begin
			px_s7   <= px_s6;
			qy_s7   <= magy_c[SHY+Q_W-1:SHY];
			negy_s7 <= prody_s6[PY_W-1];
			fac_s7  <= fac_s6;
		end
		if (ld[8]) begin
			screen_x_s8 <= center_q + px_s7;
			screen_y_s8 <= center_q - py_c;
			facing_s8   <= fac_s7;
		end
	end

	assign screen_x = screen_x_s8;
	assign screen_y = screen_y_s8;
	assign facing   = facing_s8;

`ifndef NO_ASSERTIONS
	a_empty_head_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[1] |-> !in_stall)
		else $error("input stalled with stage 1 empty");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_q[1])
		else $error("accepted beat missing from stage 1");

	a_full_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q && out_stall) |-> in_stall)
		else $error("full stalled pipeline took an input beat");

	a_drain_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |-> !in_stall)
		else $error("output drained but input stalled");
`endif

endmodule
